### design/owsm_pkg.sv
// shared types, constants and the sine table generator for the omni wheel speed mixer
package owsm_pkg;

	localparam int FIELD_W   = 16;
	localparam int STEP_W    = 15;
	localparam int CFG_IDX_W = 2;
	localparam int MODE_W    = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP_NORMAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SHIFT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_FLY    = 2'd2;

	// speed modes
	localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SHIFT  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLY    = 2'd2;

	localparam logic [STEP_W-1:0] STEP_NORMAL_RST = 15'd100;
	localparam logic [STEP_W-1:0] STEP_SHIFT_RST  = 15'd200;
	localparam logic [STEP_W-1:0] STEP_FLY_RST    = 15'd300;

	// 45 degrees as a 16-bit binary angle
	localparam logic [FIELD_W-1:0] EIGHTH_TURN = 16'h2000;
	// pi/2 with 30 fraction bits
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 4;

	typedef logic signed [FIELD_W-1:0] speed_t;

	typedef struct packed {
		logic [STEP_W-1:0] step_normal;
		logic [STEP_W-1:0] step_shift;
		logic [STEP_W-1:0] step_fly;
	} step_cfg_t;

	// sine of r/2^qbits of a quarter turn, frac fraction bits, elaboration only
	function automatic logic [31:0] sine_quarter(input int unsigned r, input int unsigned qbits,
			input int unsigned frac);
		logic [63:0] q;
		logic [63:0] one;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] s;
		logic [63:0] c;
		int unsigned n;
		q   = 64'd1 << qbits;
		one = 64'd1 << frac;
		if (r == 0) begin
			return 32'd0;
		end
		if (64'(r) >= q) begin
			return 32'(one);
		end
		x    = (64'(r) * HALF_PI_Q30 + (q >> 1)) >> qbits;
		x2   = (x * x) >> 30;
		term = x;
		pos  = x;
		neg  = 64'd0;
		for (n = 2; n <= 16; n += 2) begin
			term = ((term * x2) >> 30) / 64'(n * (n + 1));
			if (((n >> 1) & 1) != 0) begin
				neg += term;
			end else begin
				pos += term;
			end
		end
		s = (pos > neg) ? (pos - neg) : 64'd0;
		c = (s + (64'd1 << (29 - frac))) >> (30 - frac);
		if (c > one) begin
			c = one;
		end
		return 32'(c);
	endfunction

endpackage

### design/omni_wheel_speed_mixer_unit.sv
// omni wheel speed mixer top level: configuration registers, front end, middle queue, back end
//
// usage
//   input side looks like a queue: an item transfers on a clock edge with push high and
//   full low. it carries target forward/lateral speed, spin rate, heading offset and mode.
//   result side looks like a queue: while empty is low the oldest four wheel targets sit on
//   the wheel ports, and they transfer on an edge with pop high.
//   configuration: cfg_index/cfg_data transfer when cfg_valid and cfg_ready are high;
//   cfg_ready is always high; an index beyond the step registers is ignored.
// timing
//   one item per cycle sustained while full is low; a result passes the middle queue, the
//   multiply stage, the mix stage and the result queue on its way to the wheel ports.
//   the smoothed speeds update in the transfer cycle, so items may follow back to back.
// reset
//   arst_n low clears both queues, the pipeline and the smoothed speeds; step registers
//   return to 100, 200 and 300. no clearing pass is needed.
// stall
//   when pop stays low the four-entry result queue fills, the back end stops draining the
//   two-entry middle queue, and full rises once that queue is full too.
module omni_wheel_speed_mixer_unit import owsm_pkg::*; #(
	parameter int TRIG_TABLE_BITS = 8,
	parameter int COEF_FRAC_BITS  = 15
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  speed_t               target_forward,
	input  speed_t               target_lateral,
	input  speed_t               spin_rate,
	input  logic [FIELD_W-1:0]   heading_offset,
	input  logic [MODE_W-1:0]    speed_mode,
	output logic                 empty,
	input  logic                 pop,
	output speed_t               wheel_front_right,
	output speed_t               wheel_rear_right,
	output speed_t               wheel_rear_left,
	output speed_t               wheel_front_left,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [STEP_W-1:0]    cfg_data
);

	// middle queue entry: smoothed speeds, spin and the four trig coefficients
	localparam int MID_W = 3 * FIELD_W + 4 * (COEF_FRAC_BITS + 2);

	step_cfg_t        step_cfg_q;
	logic             cfg_write;
	logic             mid_push;
	logic             mid_full;
	logic             mid_pop;
	logic             mid_empty;
	logic [MID_W-1:0] mid_wdata;
	logic [MID_W-1:0] mid_rdata;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_cfg_q.step_normal <= STEP_NORMAL_RST;
			step_cfg_q.step_shift  <= STEP_SHIFT_RST;
			step_cfg_q.step_fly    <= STEP_FLY_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_STEP_NORMAL: step_cfg_q.step_normal <= cfg_data;
				REG_STEP_SHIFT:  step_cfg_q.step_shift  <= cfg_data;
				REG_STEP_FLY:    step_cfg_q.step_fly    <= cfg_data;
				default:         step_cfg_q <= step_cfg_q;
			endcase
		end
	end

	// input side stalls only on a full middle queue
	assign full = mid_full;

	owsm_front #(
		.TRIG_TABLE_BITS(TRIG_TABLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_cfg      (step_cfg_q),
		.push          (push),
		.target_forward(target_forward),
		.target_lateral(target_lateral),
		.spin_rate     (spin_rate),
		.heading_offset(heading_offset),
		.speed_mode    (speed_mode),
		.mid_full      (mid_full),
		.mid_push      (mid_push),
		.mid_data      (mid_wdata)
	);

	// decouples the stateful front end from the result side stalls
	owsm_queue #(
		.WIDTH(MID_W),
		.DEPTH(MID_DEPTH)
	) u_mid_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata (mid_wdata),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (mid_rdata),
		.empty (mid_empty)
	);

	owsm_back #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.mid_empty        (mid_empty),
		.mid_data         (mid_rdata),
		.mid_pop          (mid_pop),
		.pop              (pop),
		.empty            (empty),
		.wheel_front_right(wheel_front_right),
		.wheel_rear_right (wheel_rear_right),
		.wheel_rear_left  (wheel_rear_left),
		.wheel_front_left (wheel_front_left)
	);

endmodule

### design/owsm_queue.sv
// small first-in first-out queue with combinational read of the oldest entry
module owsm_queue import owsm_pkg::*; #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= FULL_CNT)
		else $error("queue occupancy above depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> !empty)
		else $error("queue empty after a lone push");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push && cnt_q == CNT_W'(1)) |=> empty)
		else $error("queue not empty after popping its last entry");

endmodule

### design/owsm_front.sv
// front end: slew limit of the smoothed speeds and trig coefficient lookup
module owsm_front import owsm_pkg::*; #(
	parameter int TRIG_TABLE_BITS = 8,
	parameter int COEF_FRAC_BITS  = 15
) (
	input  logic                clk,
	input  logic                arst_n,
	input  step_cfg_t           step_cfg,
	input  logic                push,
	input  speed_t              target_forward,
	input  speed_t              target_lateral,
	input  speed_t              spin_rate,
	input  logic [FIELD_W-1:0]  heading_offset,
	input  logic [MODE_W-1:0]   speed_mode,
	input  logic                mid_full,
	output logic                mid_push,
	output logic [3*FIELD_W+4*(COEF_FRAC_BITS+2)-1:0] mid_data
);

	localparam int TB    = TRIG_TABLE_BITS;
	localparam int QB    = TRIG_TABLE_BITS - 2;
	localparam int QTR   = 1 << QB;
	localparam int TIX_W = TRIG_TABLE_BITS - 1;
	localparam int MAG_W = COEF_FRAC_BITS + 1;
	localparam int CW    = COEF_FRAC_BITS + 2;
	localparam logic [FIELD_W-1:0] ROUND_HALF = FIELD_W'(1 << (15 - TRIG_TABLE_BITS));
	localparam logic [TB-1:0]      QUARTER    = TB'(QTR);
	localparam logic [TIX_W-1:0]   QTR_IDX    = TIX_W'(QTR);

	speed_t            fwd_q;
	speed_t            lat_q;
	speed_t            fwd_nxt;
	speed_t            lat_nxt;
	logic [STEP_W-1:0] step;
	logic              accept;
	logic [FIELD_W-1:0] ang_a;
	logic [FIELD_W-1:0] ang_b;
	logic [TB-1:0]     idx_a;
	logic [TB-1:0]     idx_b;
	logic [TB-1:0]     lane_idx [4];
	logic signed [CW-1:0] lane_coef [4];
	logic [MAG_W-1:0]  sin_tab [QTR+1];

	function automatic speed_t slew(input speed_t cur, input speed_t tgt,
			input logic [STEP_W-1:0] stp);
		logic signed [FIELD_W:0] d;
		logic signed [FIELD_W:0] s;
		logic [FIELD_W:0]        ad;
		d  = (FIELD_W + 1)'(cur) - (FIELD_W + 1)'(tgt);
		s  = $signed({2'b00, stp});
		ad = d[FIELD_W] ? (FIELD_W + 1)'(-d) : (FIELD_W + 1)'(d);
		if (ad >= {2'b00, stp}) begin
			if (cur > tgt) begin
				return speed_t'((FIELD_W + 1)'(cur) - s);
			end
			if (cur < tgt) begin
				return speed_t'((FIELD_W + 1)'(cur) + s);
			end
		end
		return tgt;
	endfunction

	// quarter wave table, built at elaboration
	for (genvar gi = 0; gi <= QTR; gi++) begin : g_tab
		assign sin_tab[gi] = MAG_W'(sine_quarter(gi, QB, COEF_FRAC_BITS));
	end

	always_comb begin
		case (speed_mode)
			MODE_SHIFT: step = step_cfg.step_shift;
			MODE_FLY:   step = step_cfg.step_fly;
			default:    step = step_cfg.step_normal;
		endcase
	end

	assign accept   = push & ~mid_full;
	assign mid_push = accept;
	assign fwd_nxt  = slew(fwd_q, target_forward, step);
	assign lat_nxt  = slew(lat_q, target_lateral, step);

	// a = 45 deg - heading, b = 45 deg + heading, rounded to table resolution
	assign ang_a = EIGHTH_TURN - heading_offset + ROUND_HALF;
	assign ang_b = EIGHTH_TURN + heading_offset + ROUND_HALF;
	assign idx_a = ang_a[FIELD_W-1 -: TB];
	assign idx_b = ang_b[FIELD_W-1 -: TB];

	assign lane_idx[0] = idx_a;
	assign lane_idx[1] = idx_a + QUARTER;
	assign lane_idx[2] = idx_b;
	assign lane_idx[3] = idx_b + QUARTER;

	for (genvar li = 0; li < 4; li++) begin : g_lane
		logic [1:0]       quad;
		logic [TIX_W-1:0] r_ext;
		logic [TIX_W-1:0] tidx;
		logic signed [CW-1:0] mag;
		assign quad  = lane_idx[li][TB-1 -: 2];
		assign r_ext = {1'b0, lane_idx[li][QB-1:0]};
		assign tidx  = quad[0] ? (QTR_IDX - r_ext) : r_ext;
		assign mag   = $signed({1'b0, sin_tab[tidx]});
		assign lane_coef[li] = quad[1] ? -mag : mag;
	end

	assign mid_data = {fwd_nxt, lat_nxt, spin_rate,
		lane_coef[0], lane_coef[1], lane_coef[2], lane_coef[3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= '0;
			lat_q <= '0;
		end else if (accept) begin
			fwd_q <= fwd_nxt;
			lat_q <= lat_nxt;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && step == '0 && fwd_q != target_forward) |=> $stable(fwd_q))
		else $error("forward speed moved with a zero step");
	assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ($stable(fwd_q) && $stable(lat_q)))
		else $error("smoothed speeds changed without a transfer");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && mid_full) |-> !mid_push)
		else $error("push into a full middle queue");

endmodule

### design/owsm_back.sv
// back end: wheel products, mixing, rounding, saturation and the result queue
module owsm_back import owsm_pkg::*; #(
	parameter int COEF_FRAC_BITS = 15
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   mid_empty,
	input  logic [3*FIELD_W+4*(COEF_FRAC_BITS+2)-1:0] mid_data,
	output logic   mid_pop,
	input  logic   pop,
	output logic   empty,
	output speed_t wheel_front_right,
	output speed_t wheel_rear_right,
	output speed_t wheel_rear_left,
	output speed_t wheel_front_left
);

	localparam int CW    = COEF_FRAC_BITS + 2;
	localparam int PW    = CW + FIELD_W;
	localparam int AW    = COEF_FRAC_BITS + 19;
	localparam int RW    = AW - COEF_FRAC_BITS;
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);
	localparam int OW    = 4 * FIELD_W;
	localparam logic [CNT_W-1:0]  CREDITS = CNT_W'(OUT_DEPTH);
	localparam logic [AW-1:0]     RND     = AW'(1) << (COEF_FRAC_BITS - 1);

	speed_t fx;
	speed_t ly;
	speed_t spin;
	logic signed [CW-1:0] sa;
	logic signed [CW-1:0] ca;
	logic signed [CW-1:0] sb;
	logic signed [CW-1:0] cb;

	logic take;
	logic out_pop;
	logic out_full;
	logic [CNT_W-1:0] cnt_q;

	logic vld_s1_q;
	logic signed [PW-1:0] p_ca_s1;
	logic signed [PW-1:0] p_sa_s1;
	logic signed [PW-1:0] p_cb_s1;
	logic signed [PW-1:0] p_sb_s1;
	speed_t spin_s1;

	logic signed [AW-1:0] base;
	logic signed [AW-1:0] e_ca;
	logic signed [AW-1:0] e_sa;
	logic signed [AW-1:0] e_cb;
	logic signed [AW-1:0] e_sb;
	logic signed [AW-1:0] acc [4];

	logic vld_s2_q;
	speed_t wheel_s2 [4];
	logic [OW-1:0] out_rdata;

	function automatic speed_t sat16(input logic signed [AW-1:0] a);
		logic signed [RW-1:0] r;
		r = a[AW-1:COEF_FRAC_BITS];
		if (r > RW'(32767)) begin
			return 16'sh7fff;
		end
		if (r < -RW'(32768)) begin
			return 16'sh8000;
		end
		return speed_t'(r);
	endfunction

	assign {fx, ly, spin, sa, ca, sb, cb} = mid_data;

	// a slot in the result queue is reserved before an item enters the pipeline
	assign out_pop = pop & ~empty;
	assign take    = ~mid_empty & ((cnt_q < CREDITS) | out_pop);
	assign mid_pop = take;

	always_ff @(posedge clk) begin
		if (take) begin
			p_ca_s1 <= ca * fx;
			p_sa_s1 <= sa * ly;
			p_cb_s1 <= cb * fx;
			p_sb_s1 <= sb * ly;
			spin_s1 <= spin;
		end
	end

	// spin scaled to the coefficient point with the rounding half folded in
	assign base = (AW'(spin_s1) <<< COEF_FRAC_BITS) | RND;
	assign e_ca = AW'(p_ca_s1);
	assign e_sa = AW'(p_sa_s1);
	assign e_cb = AW'(p_cb_s1);
	assign e_sb = AW'(p_sb_s1);

	assign acc[0] = base + e_ca + e_sa;
	assign acc[1] = base + e_cb - e_sb;
	assign acc[2] = base - e_ca - e_sa;
	assign acc[3] = base - e_cb + e_sb;

	always_ff @(posedge clk) begin
		if (vld_s1_q) begin
			for (int i = 0; i < 4; i++) begin
				wheel_s2[i] <= sat16(acc[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1_q <= 1'b0;
			vld_s2_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			vld_s1_q <= take;
			vld_s2_q <= vld_s1_q;
			case ({take, out_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	owsm_queue #(
		.WIDTH(OW),
		.DEPTH(OUT_DEPTH)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (vld_s2_q),
		.wdata ({wheel_s2[0], wheel_s2[1], wheel_s2[2], wheel_s2[3]}),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_rdata),
		.empty (empty)
	);

	assign {wheel_front_right, wheel_rear_right, wheel_rear_left, wheel_front_left} = out_rdata;

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CREDITS)
		else $error("back end holds more items than it has credits");
	assert property (@(posedge clk) disable iff (!arst_n) vld_s2_q |-> !out_full)
		else $error("result reaches a full result queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (empty && !vld_s1_q && !vld_s2_q))
		else $error("credit count lost track of an item");
	assert property (@(posedge clk) disable iff (!arst_n) take |-> ##2 vld_s2_q)
		else $error("item dropped inside the back pipeline");

endmodule

### bench/omni_wheel_speed_mixer_unit_tb.sv
// self-checking testbench for the omni wheel speed mixer top level
module omni_wheel_speed_mixer_unit_tb;
	import owsm_pkg::*;

	localparam int TRIG_BITS      = 8;
	localparam int COEF_BITS      = 15;
	localparam int QUARTER_BITS   = TRIG_BITS - 2;
	// time from an input transfer until its result is on the wheel ports
	localparam int RESULT_LATENCY = 3;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS    = 400;
	localparam int MAX_REPORTS    = 10;

	// codes with no name in the package
	localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

	typedef struct {
		speed_t             fwd;
		speed_t             lat;
		speed_t             spin;
		logic [FIELD_W-1:0] heading;
		logic [MODE_W-1:0]  mode;
	} motion_cmd_t;

	typedef struct {
		speed_t fr;
		speed_t rr;
		speed_t rl;
		speed_t fl;
	} wheel_set_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	speed_t               target_forward = '0;
	speed_t               target_lateral = '0;
	speed_t               spin_rate = '0;
	logic [FIELD_W-1:0]   heading_offset = '0;
	logic [MODE_W-1:0]    speed_mode = MODE_NORMAL;
	logic                 empty;
	logic                 pop = 1'b0;
	speed_t               wheel_front_right;
	speed_t               wheel_rear_right;
	speed_t               wheel_rear_left;
	speed_t               wheel_front_left;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_STEP_NORMAL;
	logic [STEP_W-1:0]    cfg_data = '0;

	// predictor state: step registers and the two smoothed speeds
	logic [STEP_W-1:0] step_normal_q = STEP_NORMAL_RST;
	logic [STEP_W-1:0] step_shift_q  = STEP_SHIFT_RST;
	logic [STEP_W-1:0] step_fly_q    = STEP_FLY_RST;
	speed_t            smooth_fwd = '0;
	speed_t            smooth_lat = '0;

	// wheel targets waiting for their result transfer, oldest first
	wheel_set_t wheel_queue[$];

	// last random targets, reused so the smoothed speeds can catch up
	speed_t last_fwd = '0;
	speed_t last_lat = '0;

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_req = 1'b0;
	int  fail_count = 0;
	int  cmds_sent = 0;
	int  results_seen = 0;
	int  cfg_writes = 0;
	int  quiet_cycles = 0;
	int  full_cycles = 0;

	omni_wheel_speed_mixer_unit #(
		.TRIG_TABLE_BITS(TRIG_BITS),
		.COEF_FRAC_BITS (COEF_BITS)
	) DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.target_forward   (target_forward),
		.target_lateral   (target_lateral),
		.spin_rate        (spin_rate),
		.heading_offset   (heading_offset),
		.speed_mode       (speed_mode),
		.empty            (empty),
		.pop              (pop),
		.wheel_front_right(wheel_front_right),
		.wheel_rear_right (wheel_rear_right),
		.wheel_rear_left  (wheel_rear_left),
		.wheel_front_left (wheel_front_left),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// sine of r/2^QUARTER_BITS of a quarter turn, taylor series in q30, then rounded
	function automatic longint quarter_sine(input int unsigned r);
		longint unsigned q;
		longint unsigned one;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned s;
		longint unsigned c;
		int unsigned     n;
		q   = 64'd1 << QUARTER_BITS;
		one = 64'd1 << COEF_BITS;
		if (r == 0) begin
			return 0;
		end
		if (64'(r) >= q) begin
			return longint'(one);
		end
		x    = (64'(r) * HALF_PI_Q30 + (q >> 1)) / q;
		x2   = (x * x) >> 30;
		term = x;
		pos  = x;
		neg  = 0;
		// odd powers alternate sign: x^3, x^7, ... subtract
		for (n = 2; n <= 16; n += 2) begin
			term = ((term * x2) >> 30) / (64'(n) * 64'(n + 1));
			if (((n / 2) % 2) == 1) begin
				neg += term;
			end else begin
				pos += term;
			end
		end
		s = (pos > neg) ? (pos - neg) : 64'd0;
		c = (s + (64'd1 << (29 - COEF_BITS))) >> (30 - COEF_BITS);
		if (c > one) begin
			c = one;
		end
		return longint'(c);
	endfunction

	// full-turn sine by quadrant folding
	function automatic longint table_sine(input int unsigned i);
		int unsigned idx;
		int unsigned quad;
		int unsigned r;
		longint      v;
		idx  = i % (1 << TRIG_BITS);
		quad = idx >> QUARTER_BITS;
		r    = idx % (1 << QUARTER_BITS);
		v    = ((quad & 1) != 0) ? quarter_sine((1 << QUARTER_BITS) - r) : quarter_sine(r);
		return ((quad & 2) != 0) ? -v : v;
	endfunction

	// binary angle to table index, ties round up, wraps
	function automatic int unsigned angle_to_index(input logic [FIELD_W-1:0] ang);
		logic [FIELD_W-1:0] t;
		t = ang + FIELD_W'(1 << (15 - TRIG_BITS));
		return int'(t >> (16 - TRIG_BITS));
	endfunction

	function automatic speed_t slew_toward(input speed_t cur, input speed_t tgt, input int step);
		int d;
		int ad;
		d  = int'(cur) - int'(tgt);
		ad = (d < 0) ? -d : d;
		if (ad >= step) begin
			if (cur > tgt) begin
				return speed_t'(int'(cur) - step);
			end
			if (cur < tgt) begin
				return speed_t'(int'(cur) + step);
			end
		end
		return tgt;
	endfunction

	// exact sum plus spin, rounded half up, saturated to 16 bits
	function automatic speed_t wheel_sum(input longint cf, input longint ls, input speed_t spin);
		longint acc;
		longint v;
		acc = cf + ls + (longint'(spin) <<< COEF_BITS);
		v   = (acc + (longint'(1) <<< (COEF_BITS - 1))) >>> COEF_BITS;
		if (v > 32767) begin
			v = 32767;
		end
		if (v < -32768) begin
			v = -32768;
		end
		return speed_t'(v);
	endfunction

	// mode three falls back to the normal step
	function automatic int mode_step(input logic [MODE_W-1:0] mode);
		case (mode)
			MODE_SHIFT: return int'(step_shift_q);
			MODE_FLY:   return int'(step_fly_q);
			default:    return int'(step_normal_q);
		endcase
	endfunction

	// one control tick: slew the smoothed speeds, then mix into four wheels
	function automatic wheel_set_t mixer_step(input motion_cmd_t c);
		int          step;
		int unsigned ia;
		int unsigned ib;
		longint      sa;
		longint      ca;
		longint      sb;
		longint      cb;
		longint      fx;
		longint      ly;
		wheel_set_t  w;
		step       = mode_step(c.mode);
		smooth_fwd = slew_toward(smooth_fwd, c.fwd, step);
		smooth_lat = slew_toward(smooth_lat, c.lat, step);
		ia = angle_to_index(EIGHTH_TURN - c.heading);
		ib = angle_to_index(EIGHTH_TURN + c.heading);
		sa = table_sine(ia);
		ca = table_sine(ia + (1 << QUARTER_BITS));
		sb = table_sine(ib);
		cb = table_sine(ib + (1 << QUARTER_BITS));
		fx = longint'(smooth_fwd);
		ly = longint'(smooth_lat);
		w.fr = wheel_sum(ca * fx, sa * ly, c.spin);
		w.rr = wheel_sum(cb * fx, -sb * ly, c.spin);
		w.rl = wheel_sum(-ca * fx, -sa * ly, c.spin);
		w.fl = wheel_sum(-cb * fx, sb * ly, c.spin);
		return w;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic motion_cmd_t make_cmd(input speed_t fwd, input speed_t lat,
			input speed_t spin, input logic [FIELD_W-1:0] heading, input logic [MODE_W-1:0] mode);
		motion_cmd_t c;
		c.fwd     = fwd;
		c.lat     = lat;
		c.spin    = spin;
		c.heading = heading;
		c.mode    = mode;
		return c;
	endfunction

	// a target within about one step of the smoothed speed
	function automatic speed_t near_value(input speed_t base, input int step);
		int v;
		v = int'(base) + int'($urandom_range(2 * step + 2)) - (step + 1);
		if (v > 32767) begin
			v = 32767;
		end
		if (v < -32768) begin
			v = -32768;
		end
		return speed_t'(v);
	endfunction

	function automatic speed_t extreme_value();
		case ($urandom_range(4))
			0:       return speed_t'(-32768);
			1:       return speed_t'(32767);
			2:       return speed_t'(-1);
			3:       return speed_t'(1);
			default: return speed_t'(0);
		endcase
	endfunction

	// mostly held or nearby targets so slewing settles, with full-range noise mixed in
	function automatic motion_cmd_t random_cmd();
		motion_cmd_t c;
		int          step;
		c.mode = MODE_W'($urandom_range(3));
		step   = mode_step(c.mode);
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				c.fwd = speed_t'($urandom);
				c.lat = speed_t'($urandom);
			end
			4, 5, 6: begin
				c.fwd = last_fwd;
				c.lat = last_lat;
			end
			7, 8: begin
				c.fwd = near_value(smooth_fwd, step);
				c.lat = near_value(smooth_lat, step);
			end
			default: begin
				c.fwd = extreme_value();
				c.lat = extreme_value();
			end
		endcase
		last_fwd = c.fwd;
		last_lat = c.lat;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5, 6: c.spin = speed_t'(int'($urandom_range(2048)) - 1024);
			7, 8:                c.spin = speed_t'($urandom);
			default:             c.spin = extreme_value();
		endcase
		// low byte 0x80 puts both angles exactly on a rounding tie
		if ($urandom_range(9) == 0) begin
			c.heading = {8'($urandom), 8'h80};
		end else begin
			c.heading = FIELD_W'($urandom);
		end
		return c;
	endfunction

	// ---------------------------------------------------------------- driver tasks

	// random sender gap after a transfer; push stays high when no gap is taken
	task automatic idle_gap();
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// offer one command and wait for its transfer
	task automatic send_cmd(input motion_cmd_t c);
		push           <= 1'b1;
		target_forward <= c.fwd;
		target_lateral <= c.lat;
		spin_rate      <= c.spin;
		heading_offset <= c.heading;
		speed_mode     <= c.mode;
		do @(posedge clk); while (full);
		wheel_queue.push_back(mixer_step(c));
		cmds_sent++;
		idle_gap();
	endtask

	// stop sending until every expected result has transferred out
	task automatic wait_drained();
		push <= 1'b0;
		while (wheel_queue.size() != 0) @(posedge clk);
		repeat (RESULT_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_step(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_STEP_NORMAL: step_normal_q = val;
			REG_STEP_SHIFT:  step_shift_q  = val;
			REG_STEP_FLY:    step_fly_q    = val;
			default: ;
		endcase
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_steps(input logic [STEP_W-1:0] norm, input logic [STEP_W-1:0] shift,
			input logic [STEP_W-1:0] fly);
		wait_drained();
		write_step(REG_STEP_NORMAL, norm);
		write_step(REG_STEP_SHIFT, shift);
		write_step(REG_STEP_FLY, fly);
	endtask

	// ---------------------------------------------------------------- tests

	// reset step values 100/200/300, every mode, heading ties and quarter points
	task automatic test_reset_steps();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// exactly one step away, then well inside one step
		send_cmd(make_cmd(100, -100, 0, 16'h0000, MODE_NORMAL));
		send_cmd(make_cmd(150, -150, 0, 16'h0000, MODE_NORMAL));
		send_cmd(make_cmd(32767, -32768, 0, 16'h4000, MODE_SHIFT));
		send_cmd(make_cmd(32767, -32768, 0, 16'h8000, MODE_FLY));
		// mode three uses the normal step
		send_cmd(make_cmd(0, 0, 1, 16'h1F80, MODE_SPARE));
		send_cmd(make_cmd(0, 0, -1, 16'h0080, MODE_FLY));
		send_cmd(make_cmd(-32768, 32767, -1, 16'hE000, MODE_FLY));
		send_cmd(make_cmd(0, 0, 0, 16'hFFFF, MODE_FLY));
		send_cmd(make_cmd(0, 0, 0, 16'h7FFF, MODE_FLY));
	endtask

	// largest, zero and unit steps; wheel sums pushed past both rails
	task automatic test_saturation_and_steps();
		apply_steps(15'h7FFF, 15'd0, 15'd1);
		repeat (3) send_cmd(make_cmd(32767, 32767, 32767, 16'h0000, MODE_NORMAL));
		repeat (3) send_cmd(make_cmd(-32768, -32768, -32768, 16'h8000, MODE_NORMAL));
		// zero step holds, unless the target is already reached
		send_cmd(make_cmd(0, 0, 0, 16'h0000, MODE_SHIFT));
		send_cmd(make_cmd(-32768, -32768, 5, 16'h4000, MODE_SHIFT));
		send_cmd(make_cmd(-32767, -32766, 0, 16'h1234, MODE_FLY));
		send_cmd(make_cmd(12345, -23456, -32768, 16'hC000, MODE_SPARE));
	endtask

	// index three is not a register: the normal step must keep its value
	task automatic test_ignored_register();
		wait_drained();
		write_step(REG_SPARE, 15'd0);
		send_cmd(make_cmd(0, 0, 0, 16'h2000, MODE_NORMAL));
		send_cmd(make_cmd(-32768, 32767, 100, 16'hA000, MODE_NORMAL));
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		repeat (PHASE_ITEMS) send_cmd(random_cmd());
	endtask

	// result side held off long enough for full to rise while commands keep coming
	task automatic test_input_stall();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b1;
		repeat (60) send_cmd(random_cmd());
	endtask

	// sender stops until everything is out, then picks up again
	task automatic test_drain_pause();
		send_idle_pct  = 30;
		recv_stall_pct = 77;
		repeat (25) send_cmd(random_cmd());
		wait_drained();
		repeat (25) send_cmd(random_cmd());
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_failure(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS) begin
			$display("mismatch: %s", what);
		end
	endtask

	task automatic check_wheel(input string name, input speed_t want, input speed_t got);
		if (want !== got) begin
			report_failure($sformatf("%s result %0d expected %0d got %0d",
				name, results_seen, want, got));
		end
	endtask

	// long hold-off on the result side, counted here
	initial begin
		forever begin
			wait (hold_req);
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_req = 1'b0;
		end
	end

	// result side: check every transfer against the oldest expectation, then pick pop
	initial begin
		wheel_set_t want;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (wheel_queue.size() == 0) begin
					report_failure($sformatf("result transfer %0d with nothing expected",
						results_seen));
				end else begin
					want = wheel_queue.pop_front();
					check_wheel("wheel_front_right", want.fr, wheel_front_right);
					check_wheel("wheel_rear_right", want.rr, wheel_rear_right);
					check_wheel("wheel_rear_left", want.rl, wheel_rear_left);
					check_wheel("wheel_front_left", want.fl, wheel_front_left);
				end
				results_seen++;
			end
			pop <= hold_req ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: too long with no transfer of any kind ends the run
	always @(posedge clk) begin
		if (push && full) begin
			full_cycles <= full_cycles + 1;
		end
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, wheel_queue.size());
			$display("omni_wheel_speed_mixer_unit verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_steps();
		test_saturation_and_steps();
		test_ignored_register();

		apply_steps(STEP_W'($urandom_range(1, 500)), STEP_W'($urandom_range(1, 500)),
			STEP_W'($urandom_range(1, 500)));
		test_random_traffic(0, 0);
		test_input_stall();

		apply_steps(15'd0, 15'h7FFF, STEP_W'($urandom));
		test_random_traffic(77, 0);
		test_drain_pause();

		apply_steps(STEP_W'($urandom), STEP_W'($urandom), STEP_W'($urandom));
		test_random_traffic(0, 77);

		apply_steps(STEP_W'($urandom_range(1, 64)), STEP_W'($urandom_range(1, 64)),
			STEP_W'($urandom_range(1, 64)));
		test_random_traffic(30, 30);

		// everything out, plus the pipeline depth to catch stray results
		wait_drained();

		$display("run covered %0d commands, %0d wheel results, %0d register writes",
			cmds_sent, results_seen, cfg_writes);
		$display("input stalled by full for %0d cycles; %0d mismatches", full_cycles,
			fail_count);
		if (fail_count == 0) begin
			$display("omni_wheel_speed_mixer_unit verification clean");
		end else begin
			$display("omni_wheel_speed_mixer_unit verification failed");
		end
		$finish;
	end

endmodule
